@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files; the top-level formatter includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/ssnf_pkg.sv @@
`timescale 1ns / 1ps

package ssnf_pkg;

    localparam int DIGIT_COUNT = 13;
    localparam int OP_W        = 2;
    localparam int VALUE_W     = 24;
    localparam int LOW_W       = 56;
    localparam int HIGH_W      = 48;

    localparam logic [VALUE_W-1:0] SPEED_LIMIT = 24'd512;
    localparam logic [VALUE_W-1:0] TRIP_LIMIT  = 24'd9999;
    localparam logic [7:0]         POINT_MASK  = 8'h80;

    typedef enum logic [OP_W-1:0] {
        OP_SPEED = 2'd0,
        OP_TRIP  = 2'd1,
        OP_DIST  = 2'd2
    } t_op;

    typedef logic [DIGIT_COUNT-1:0][7:0] t_seg_buf;

    typedef struct packed {
        t_seg_buf seg_buf;
        logic     over;
    } t_fmt_result;

endpackage

@@ rtl/ssnf_if.sv @@
`timescale 1ns / 1ps

interface ssnf_in_if;
    logic                          valid;
    logic                          ready;
    logic [ssnf_pkg::OP_W-1:0]     operation;
    logic [ssnf_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface ssnf_out_if;
    logic                          valid;
    logic                          ready;
    logic [ssnf_pkg::LOW_W-1:0]    digits_low;
    logic [ssnf_pkg::HIGH_W-1:0]   digits_high;
    logic                          speed_over_range;

    modport source (output valid, output digits_low, output digits_high,
                    output speed_over_range, input ready);
    modport sink   (input valid, input digits_low, input digits_high,
                    input speed_over_range, output ready);
endinterface

@@ rtl/ssnf_bcd_split.sv @@
`timescale 1ns / 1ps

// Splits a value below 10000 into four decimal digits. Each quotient is
// taken straight from the input by a reciprocal multiply, so the three
// constant multipliers run side by side rather than in a chain.
module ssnf_bcd_split (
    input  logic [13:0] i_value,
    output logic [3:0]  o_d0,
    output logic [3:0]  o_d1,
    output logic [3:0]  o_d2,
    output logic [3:0]  o_d3
);

    logic [29:0] p10;
    logic [26:0] p100;
    logic [28:0] p1000;
    logic [10:0] q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [13:0] rem0;
    logic [10:0] rem1;
    logic [6:0]  rem2;

    always_comb begin
        p10   = {16'd0, i_value} * 30'd52429;
        p100  = {13'd0, i_value} * 27'd5243;
        p1000 = {15'd0, i_value} * 29'd16778;
        q10   = p10[29:19];
        q100  = p100[25:19];
        q1000 = p1000[27:24];
        rem0  = i_value - ({3'd0, q10} * 14'd10);
        rem1  = q10 - ({4'd0, q100} * 11'd10);
        rem2  = q100 - ({3'd0, q1000} * 7'd10);
        o_d0  = rem0[3:0];
        o_d1  = rem1[3:0];
        o_d2  = rem2[3:0];
        o_d3  = q1000;
    end

endmodule

@@ rtl/ssnf_format.sv @@
`timescale 1ns / 1ps

// Builds the next pattern buffer from the current one and one update word, and flags a speed over the limit.
module ssnf_format (
    input  logic [ssnf_pkg::OP_W-1:0]    i_op,
    input  logic [ssnf_pkg::VALUE_W-1:0] i_value,
    input  ssnf_pkg::t_seg_buf           i_buf,
    output ssnf_pkg::t_fmt_result        o_result
);

    function automatic logic [7:0] f_seg(input logic [4:0] d);
        logic [7:0] pat;
        case (d)
            5'd0:    pat = 8'h3F;
            5'd1:    pat = 8'h06;
            5'd2:    pat = 8'h5B;
            5'd3:    pat = 8'h4F;
            5'd4:    pat = 8'h66;
            5'd5:    pat = 8'h6D;
            5'd6:    pat = 8'h7D;
            5'd7:    pat = 8'h07;
            5'd8:    pat = 8'h7F;
            5'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

    logic [13:0] trip_value;
    logic [13:0] split_in;
    logic [3:0]  d0, d1, d2, d3;
    logic [7:0]  byte_val [3];
    logic [15:0] byte_prod [3];
    logic [4:0]  byte_hi [3];
    logic [7:0]  byte_rem [3];

    ssnf_bcd_split u_split (
        .i_value (split_in),
        .o_d0    (d0),
        .o_d1    (d1),
        .o_d2    (d2),
        .o_d3    (d3)
    );

    always_comb begin
        trip_value = (i_value > ssnf_pkg::TRIP_LIMIT) ? 14'd0 : i_value[13:0];
        split_in   = (i_op == ssnf_pkg::OP_TRIP) ? trip_value : {4'd0, i_value[9:0]};
    end

    // Distance bytes: b / 10 as (b * 205) >> 11, exact over the whole byte range.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            byte_val[k]  = i_value[8*k +: 8];
            byte_prod[k] = {8'd0, byte_val[k]} * 16'd205;
            byte_hi[k]   = byte_prod[k][15:11];
            byte_rem[k]  = byte_val[k] - ({3'd0, byte_hi[k]} * 8'd10);
        end
    end

    always_comb begin
        o_result.seg_buf = i_buf;
        o_result.over    = 1'b0;
        unique case (ssnf_pkg::t_op'(i_op))
            ssnf_pkg::OP_SPEED: begin
                if (i_value > ssnf_pkg::SPEED_LIMIT) begin
                    o_result.over = 1'b1;
                end else begin
                    o_result.seg_buf[2] = (d2 != 4'd0) ? f_seg({1'b0, d2}) : 8'h00;
                    o_result.seg_buf[1] = (d2 != 4'd0 || d1 != 4'd0) ?
                                          f_seg({1'b0, d1}) : 8'h00;
                    o_result.seg_buf[0] = f_seg({1'b0, d0});
                end
            end
            ssnf_pkg::OP_TRIP: begin
                o_result.seg_buf[6] = (d3 != 4'd0) ? f_seg({1'b0, d3}) : 8'h00;
                o_result.seg_buf[5] = (d3 != 4'd0 || d2 != 4'd0) ?
                                      f_seg({1'b0, d2}) : 8'h00;
                o_result.seg_buf[4] = f_seg({1'b0, d1}) | ssnf_pkg::POINT_MASK;
                o_result.seg_buf[3] = f_seg({1'b0, d0});
            end
            ssnf_pkg::OP_DIST: begin
                for (int k = 0; k < 3; k++) begin
                    o_result.seg_buf[7 + 2*k] = f_seg({1'b0, byte_rem[k][3:0]});
                    o_result.seg_buf[8 + 2*k] = f_seg(byte_hi[k]);
                end
            end
            default: begin
                o_result.seg_buf = i_buf;
            end
        endcase
    end

endmodule

@@ rtl/seven_segment_number_formatter.sv @@
// Flow: a word accepted into the input register is formatted from it and moves to
// the output register, and so to the output channel, once that register is free.
// Throughput: one word per cycle; the input register, the single formatting
// stage and the output register all move every cycle when the sink is ready.
// Reset: synchronous, active low; clears both valid flags, blanks the live buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module seven_segment_number_formatter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ssnf_in_if.sink         i_in,
    ssnf_out_if.source      o_out
);

    logic                          r_in_valid;
    logic [ssnf_pkg::OP_W-1:0]     r_in_op;
    logic [ssnf_pkg::VALUE_W-1:0]  r_in_value;
    ssnf_pkg::t_seg_buf            r_buf;
    logic                          r_out_valid;
    ssnf_pkg::t_seg_buf            r_out_buf;
    logic                          r_out_over;

    ssnf_pkg::t_fmt_result         fmt;
    logic                          out_free;
    logic                          advance;

    ssnf_format u_format (
        .i_op     (r_in_op),
        .i_value  (r_in_value),
        .i_buf    (r_buf),
        .o_result (fmt)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid            = r_out_valid;
    assign o_out.digits_low       = r_out_buf[6:0];
    assign o_out.digits_high      = r_out_buf[12:7];
    assign o_out.speed_over_range = r_out_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_buf       <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_buf       <= fmt.seg_buf;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op    <= i_in.operation;
            r_in_value <= i_in.value;
        end
        if (advance) begin
            r_out_buf  <= fmt.seg_buf;
            r_out_over <= fmt.over;
        end
    end

    // While a word is shown, it mirrors the live buffer, since both load together.
    `ASSERT_IMPL(a_out_mirrors_buf, i_clk, i_rst_n, r_out_valid, r_out_buf == r_buf)
    `ASSERT_NEXT(a_buf_holds_idle, i_clk, i_rst_n, !advance, $stable(r_buf))
    `ASSERT_NEXT(a_over_keeps_buf, i_clk, i_rst_n, advance && fmt.over, $stable(r_buf))
    `ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid)

endmodule

@@ verif/seven_segment_number_formatter_tb.sv @@
`timescale 1ns / 1ps

module seven_segment_number_formatter_tb;
    import ssnf_pkg::*;

    localparam int                HALF_PERIOD   = 4;
    localparam int                RESET_CYCLES  = 9;
    localparam int                HEAVY_PCT     = 55;
    localparam int                LIGHT_PCT     = 16;
    localparam int                HOLD_CYCLES   = 300;
    localparam int                STUCK_LIMIT   = 4000;
    localparam int                DRAIN_CYCLES  = 8;
    localparam int                REPORT_LIMIT  = 10;
    localparam logic [OP_W-1:0]   OP_UNUSED     = 2'd3;
    localparam logic [7:0]        SEG_CODE [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                                    8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    typedef enum int {
        MODE_FREE,
        MODE_SRC_IDLE,
        MODE_SNK_STALL,
        MODE_BOTH,
        MODE_HOLD
    } traffic_mode_e;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } update_word_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    traffic_mode_e mode;

    ssnf_in_if  in_if ();
    ssnf_out_if out_if ();

    seven_segment_number_formatter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    update_word_t pending_updates[$];
    t_fmt_result  expected_frames[$];
    t_seg_buf     shadow_digits = '0;
    int           mismatches = 0;
    int           hold_count = 0;
    bit           hold_done = 1'b0;
    int           stuck_cycles = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [7:0] segment_of(int unsigned d);
        if (d > 9) begin
            return 8'h00;
        end
        return SEG_CODE[d[3:0]];
    endfunction

    // Updates the shadow copy of the display buffer and returns the word that
    // the block should send for this update.
    function automatic t_fmt_result apply_update(update_word_t w);
        t_fmt_result  r;
        int unsigned  v;
        int unsigned  d0, d1, d2, d3;
        int unsigned  b;

        r.over = 1'b0;
        v = {8'd0, w.value};
        case (w.op)
            OP_SPEED: begin
                if (v > SPEED_LIMIT) begin
                    r.over = 1'b1;
                end else begin
                    d0 = v % 10;
                    d1 = (v / 10) % 10;
                    d2 = v / 100;
                    shadow_digits[2] = (d2 != 0) ? segment_of(d2) : 8'h00;
                    shadow_digits[1] = (d2 != 0 || d1 != 0) ? segment_of(d1) : 8'h00;
                    shadow_digits[0] = segment_of(d0);
                end
            end
            OP_TRIP: begin
                if (v > TRIP_LIMIT) begin
                    v = 0;
                end
                d0 = v % 10;
                d1 = (v / 10) % 10;
                d2 = (v / 100) % 10;
                d3 = v / 1000;
                shadow_digits[6] = (d3 != 0) ? segment_of(d3) : 8'h00;
                shadow_digits[5] = (d3 != 0 || d2 != 0) ? segment_of(d2) : 8'h00;
                shadow_digits[4] = segment_of(d1) | POINT_MASK;
                shadow_digits[3] = segment_of(d0);
            end
            OP_DIST: begin
                for (int k = 0; k < 3; k++) begin
                    b = {24'd0, w.value[8*k +: 8]};
                    shadow_digits[7 + 2*k] = segment_of(b % 10);
                    shadow_digits[8 + 2*k] = segment_of(b / 10);
                end
            end
            default: begin
            end
        endcase
        r.seg_buf = shadow_digits;
        return r;
    endfunction

    function automatic update_word_t random_update();
        update_word_t w;
        int unsigned  pick;
        int unsigned  shape;

        pick  = $urandom_range(99);
        shape = $urandom_range(9);
        w.value = VALUE_W'($urandom());
        if (pick < 30) begin
            w.op = OP_SPEED;
            if (shape < 7) begin
                w.value = VALUE_W'($urandom_range(SPEED_LIMIT));
            end else if (shape < 9) begin
                w.value = VALUE_W'($urandom_range(SPEED_LIMIT + 1, 1100));
            end
        end else if (pick < 60) begin
            w.op = OP_TRIP;
            if (shape < 7) begin
                w.value = VALUE_W'($urandom_range(TRIP_LIMIT));
            end else if (shape < 9) begin
                w.value = VALUE_W'($urandom_range(TRIP_LIMIT + 1, 12000));
            end
        end else if (pick < 90) begin
            w.op = OP_DIST;
            if (shape < 9) begin
                for (int k = 0; k < 3; k++) begin
                    w.value[8*k +: 8] = ($urandom_range(4) != 0) ? 8'($urandom_range(99))
                                                                 : 8'($urandom_range(255));
                end
            end
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic queue_update(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
        update_word_t w;

        w.op    = op;
        w.value = value;
        pending_updates.push_back(w);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            pending_updates.push_back(random_update());
        end
    endtask

    task automatic wait_idle();
        while (pending_updates.size() != 0 || expected_frames.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: keeps a word steady while it waits for ready, otherwise offers
    // the next pending word unless this cycle is an idle one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.operation <= OP_SPEED;
            in_if.value     <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_frames.push_back(apply_update(pending_updates.pop_front()));
            end
            if (!(in_if.valid && !in_if.ready)) begin
                if (pending_updates.size() != 0 && !($urandom_range(99) <
                        ((mode == MODE_SRC_IDLE) ? HEAVY_PCT :
                         (mode == MODE_BOTH) ? LIGHT_PCT : 0))) begin
                    in_if.valid     <= 1'b1;
                    in_if.operation <= pending_updates[0].op;
                    in_if.value     <= pending_updates[0].value;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted word against the oldest prediction and
    // decides ready for the next cycle.
    always @(posedge i_clk) begin
        t_fmt_result exp_frame;

        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_frames.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("Unexpected word: low=%h high=%h over=%b",
                                 out_if.digits_low, out_if.digits_high,
                                 out_if.speed_over_range);
                    end
                    mismatches++;
                end else begin
                    exp_frame = expected_frames.pop_front();
                    if (out_if.digits_low !== exp_frame.seg_buf[6:0] ||
                        out_if.digits_high !== exp_frame.seg_buf[12:7] ||
                        out_if.speed_over_range !== exp_frame.over) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("Mismatch: exp %h %h %b, got %h %h %b",
                                     exp_frame.seg_buf[6:0], exp_frame.seg_buf[12:7],
                                     exp_frame.over, out_if.digits_low,
                                     out_if.digits_high, out_if.speed_over_range);
                        end
                        mismatches++;
                    end
                end
            end
            if (mode == MODE_HOLD && !hold_done) begin
                out_if.ready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES) begin
                    hold_done = 1'b1;
                end
            end else begin
                out_if.ready <= !($urandom_range(99) <
                                  ((mode == MODE_SNK_STALL) ? HEAVY_PCT :
                                   (mode == MODE_BOTH) ? LIGHT_PCT : 0));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (pending_updates.size() == 0 && expected_frames.size() == 0)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        mode    = MODE_FREE;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Speed: blanking boundaries, the top of the range and just above it.
        queue_update(OP_SPEED, 24'd0);
        queue_update(OP_SPEED, 24'd9);
        queue_update(OP_SPEED, 24'd10);
        queue_update(OP_SPEED, 24'd99);
        queue_update(OP_SPEED, 24'd100);
        queue_update(OP_SPEED, SPEED_LIMIT);
        queue_update(OP_SPEED, SPEED_LIMIT + 24'd1);
        queue_update(OP_SPEED, 24'hFFFFFF);
        // Trip: blanking of thousands and hundreds, and values that wrap to zero.
        queue_update(OP_TRIP, 24'd0);
        queue_update(OP_TRIP, 24'd9);
        queue_update(OP_TRIP, 24'd10);
        queue_update(OP_TRIP, 24'd99);
        queue_update(OP_TRIP, 24'd100);
        queue_update(OP_TRIP, 24'd999);
        queue_update(OP_TRIP, 24'd1000);
        queue_update(OP_TRIP, TRIP_LIMIT);
        queue_update(OP_TRIP, TRIP_LIMIT + 24'd1);
        queue_update(OP_TRIP, 24'hFFFFFF);
        // Distance: all zero, all 99, bytes above 99 and a mixed set.
        queue_update(OP_DIST, 24'h000000);
        queue_update(OP_DIST, 24'h636363);
        queue_update(OP_DIST, 24'hFFFFFF);
        queue_update(OP_DIST, 24'h0A6410);
        queue_update(OP_UNUSED, 24'h123456);
        wait_idle();

        queue_random(300);
        wait_idle();

        mode = MODE_SRC_IDLE;
        queue_random(350);
        wait_idle();

        mode = MODE_SNK_STALL;
        queue_random(350);
        wait_idle();

        mode = MODE_BOTH;
        queue_random(350);
        wait_idle();

        // The sink holds off for a long stretch while words keep coming.
        mode = MODE_HOLD;
        queue_random(300);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ssnf_pkg.sv
rtl/ssnf_if.sv
rtl/ssnf_bcd_split.sv
rtl/ssnf_format.sv
rtl/seven_segment_number_formatter.sv
verif/seven_segment_number_formatter_tb.sv
